[sv/pcsd_pkg.sv]
// ----------------------------------------------------------------------------
// pcsd_pkg
// Shared types and constants of the path corner slowdown detector.
// ----------------------------------------------------------------------------
package pcsd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_THR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_SPEED = 1'b1;

  localparam int unsigned THR_W     = 16;  // Q2.14 cosine threshold
  localparam int unsigned CM2_W     = 32;  // square of the threshold magnitude
  localparam int unsigned DIGIT_W   = 16;  // multiplier digit per cycle
  localparam int unsigned LHS_SHIFT = 28;  // (|dot| << 14)^2 = |dot|^2 << 28

  // control part of one queued job
  typedef struct packed {
    logic test;       // middle point gets the corner test
    logic emit_mid;   // a result for the middle point is due
    logic emit_last;  // a result for the segment's last point is due
    logic mid_ov;     // middle point carries an override
    logic last_ov;    // last point carries an override
  } pcsd_job_ctl_t;

  localparam int unsigned JOB_CTL_W = $bits(pcsd_job_ctl_t);

endpackage

[sv/pcsd_mul.sv]
// ----------------------------------------------------------------------------
// pcsd_mul
// Unsigned multi-cycle multiplier: one 16-bit digit of b per cycle, stops
// early once the remaining digits of b are zero.
// ----------------------------------------------------------------------------
module pcsd_mul import pcsd_pkg::*; #(
  parameter int unsigned AW = 74,
  parameter int unsigned BW = 42,
  parameter int unsigned PW = 116
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [PW-1:0] prod_o
);

  localparam int unsigned ND    = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned CNT_W = (ND > 1) ? $clog2(ND) : 1;

  logic                   busy_q, done_q;
  logic [AW-1:0]          a_q;
  logic [BW-1:0]          b_q, b_rest;
  logic [CNT_W-1:0]       cnt_q;
  logic [PW-1:0]          acc_q;
  logic [AW+DIGIT_W-1:0]  partial;
  logic [PW-1:0]          part_ext, part_sh;

  assign partial  = a_q * b_q[DIGIT_W-1:0];
  assign part_ext = PW'(partial);
  assign part_sh  = part_ext << (cnt_q * DIGIT_W);
  assign b_rest   = b_q >> DIGIT_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_rest == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part_sh;
      b_q   <= b_rest;
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[sv/pcsd_front.sv]
// ----------------------------------------------------------------------------
// pcsd_front
// Segment tracking: keeps the last two points and turns each accepted point
// into a job for the back end, but a segment's first unless it is its last.
// ----------------------------------------------------------------------------
module pcsd_front import pcsd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 20,
  parameter int unsigned SPEED_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] x_pos_i,
  input  logic signed [COORD_WIDTH-1:0] y_pos_i,
  input  logic signed [COORD_WIDTH-1:0] z_pos_i,
  input  logic                          is_mark_i,
  input  logic                          seg_end_i,
  input  logic                          has_override_i,
  input  logic [SPEED_WIDTH-1:0]        speed_in_i,
  output logic                          push_o,
  input  logic                          q_ready_i,
  output pcsd_job_ctl_t                 job_ctl_o,
  output logic [9*COORD_WIDTH-1:0]      job_pts_o,
  output logic [2*SPEED_WIDTH-1:0]      job_spd_o
);

  localparam int unsigned PT_W = 3 * COORD_WIDTH;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_MANY = 2'd2;

  logic [PT_W-1:0]        older_q, middle_q, point;
  logic [SPEED_WIDTH-1:0] mid_spd_q, spd_eff;
  logic                   mid_ov_q, mark_q;
  logic [1:0]             seen_q;
  logic                   accept;

  assign point      = {x_pos_i, y_pos_i, z_pos_i};
  assign spd_eff    = has_override_i ? speed_in_i : '0;
  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign push_o     = accept & ((seen_q != SEEN_NONE) | seg_end_i);

  always_comb begin
    job_ctl_o.test      = (seen_q == SEEN_MANY) & mark_q;
    job_ctl_o.emit_mid  = (seen_q != SEEN_NONE);
    job_ctl_o.emit_last = seg_end_i;
    job_ctl_o.mid_ov    = mid_ov_q;
    job_ctl_o.last_ov   = has_override_i;
  end

  assign job_pts_o = {older_q, middle_q, point};
  assign job_spd_o = {mid_spd_q, spd_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q   <= '0;
      middle_q  <= '0;
      mid_spd_q <= '0;
      mid_ov_q  <= 1'b0;
      mark_q    <= 1'b0;
      seen_q    <= SEEN_NONE;
    end else if (accept) begin
      // the first point of a segment decides its type
      if (seen_q == SEEN_NONE) begin
        mark_q <= is_mark_i;
      end
      older_q   <= middle_q;
      middle_q  <= point;
      mid_spd_q <= spd_eff;
      mid_ov_q  <= has_override_i;
      if (seg_end_i) begin
        seen_q <= SEEN_NONE;
      end else if (seen_q != SEEN_MANY) begin
        seen_q <= seen_q + 2'd1;
      end
    end
  end

endmodule

[sv/pcsd_queue.sv]
// ----------------------------------------------------------------------------
// pcsd_queue
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
module pcsd_queue #(
  parameter int unsigned W = 249
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  output logic         ready_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] dout_o
);

  logic [W-1:0] ent0_q, ent1_q;
  logic [1:0]   cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign dout_o  = ent0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push_i && !pop_i) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // head always sits in entry 0
  always_ff @(posedge clk_i) begin
    if (push_i && pop_i) begin
      if (cnt_q == 2'd1) begin
        ent0_q <= din_i;
      end else begin
        ent0_q <= ent1_q;
        ent1_q <= din_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        ent0_q <= din_i;
      end else begin
        ent1_q <= din_i;
      end
    end else if (pop_i) begin
      ent0_q <= ent1_q;
    end
  end

endmodule

[sv/pcsd_back.sv]
// ----------------------------------------------------------------------------
// pcsd_back
// Corner test sequencer and result output. All products go through one
// shared digit-serial multiplier; results leave through an output register.
// ----------------------------------------------------------------------------
module pcsd_back import pcsd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 20,
  parameter int unsigned SPEED_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  output logic                     q_pop_o,
  input  pcsd_job_ctl_t            job_ctl_i,
  input  logic [9*COORD_WIDTH-1:0] job_pts_i,
  input  logic [2*SPEED_WIDTH-1:0] job_spd_i,
  input  logic [THR_W-1:0]         cos_thr_i,
  input  logic [SPEED_WIDTH-1:0]   def_speed_i,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic                     slowed_o,
  output logic                     override_o,
  output logic [SPEED_WIDTH-1:0]   speed_o,
  output logic                     last_o
);

  localparam int unsigned C  = COORD_WIDTH;
  localparam int unsigned DW = C + 1;            // coordinate difference
  localparam int unsigned SW = 2 * DW;           // sums of products
  localparam int unsigned TW = SW + CM2_W;       // s1 * c^2
  localparam int unsigned BW = (SW > CM2_W) ? SW : CM2_W;
  localparam int unsigned PW = TW + BW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_CM2  = 4'd3;
  localparam logic [3:0] ST_T1   = 4'd4;
  localparam logic [3:0] ST_T2   = 4'd5;
  localparam logic [3:0] ST_DOT  = 4'd6;
  localparam logic [3:0] ST_MID  = 4'd7;
  localparam logic [3:0] ST_LAST = 4'd8;

  localparam logic [1:0] K_X = 2'd0;
  localparam logic [1:0] K_Y = 2'd1;
  localparam logic [1:0] K_Z = 2'd2;

  localparam logic [1:0] SUB_AA = 2'd0;  // |a|^2 into s1
  localparam logic [1:0] SUB_BB = 2'd1;  // |b|^2 into s2
  localparam logic [1:0] SUB_AB = 2'd2;  // a*b into dot

  logic [3:0]             state_q, state_d;
  logic                   iss_q, iss_d;
  logic [1:0]             k_q, k_d, sub_q, sub_d;
  logic                   slow_q, slow_d;
  logic [SW-1:0]          s1_q, s1_d, s2_q, s2_d;
  logic signed [SW:0]     dot_q, dot_d;
  logic [PW-1:0]          rhs_q, rhs_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_slow_q, out_ov_q, out_last_q;
  logic [SPEED_WIDTH-1:0] out_spd_q;
  logic                   out_load, nx_slow, nx_ov, nx_last;
  logic [SPEED_WIDTH-1:0] nx_spd, mid_spd, last_spd, base_spd;

  logic [C-1:0]           c0, c1, c2;
  logic signed [DW-1:0]   da, db;
  logic [DW-1:0]          ma, mb;
  logic signed [SW:0]     dot_neg;
  logic [SW-1:0]          dmag;
  logic                   dneg;
  logic signed [THR_W-1:0] thr;
  logic [THR_W-1:0]       cm;

  logic                   mul_start, mul_done;
  logic [TW-1:0]          mul_a;
  logic [BW-1:0]          mul_b;
  logic [PW-1:0]          mul_prod, lhs;
  logic signed [SW:0]     prod_s;
  logic                   out_free;

  assign mid_spd  = job_spd_i[SPEED_WIDTH +: SPEED_WIDTH];
  assign last_spd = job_spd_i[0 +: SPEED_WIDTH];

  // coordinate k of older, middle and new point
  always_comb begin
    case (k_q)
      K_X: begin
        c0 = job_pts_i[8*C +: C];
        c1 = job_pts_i[5*C +: C];
        c2 = job_pts_i[2*C +: C];
      end
      K_Y: begin
        c0 = job_pts_i[7*C +: C];
        c1 = job_pts_i[4*C +: C];
        c2 = job_pts_i[1*C +: C];
      end
      default: begin
        c0 = job_pts_i[6*C +: C];
        c1 = job_pts_i[3*C +: C];
        c2 = job_pts_i[0 +: C];
      end
    endcase
  end

  assign da = $signed({c1[C-1], c1}) - $signed({c0[C-1], c0});
  assign db = $signed({c2[C-1], c2}) - $signed({c1[C-1], c1});
  assign ma = da[DW-1] ? DW'(-da) : DW'(da);
  assign mb = db[DW-1] ? DW'(-db) : DW'(db);

  assign dot_neg = -dot_q;
  assign dneg    = dot_q[SW];
  assign dmag    = dneg ? dot_neg[SW-1:0] : dot_q[SW-1:0];

  assign thr = $signed(cos_thr_i);
  assign cm  = thr[THR_W-1] ? THR_W'(-thr) : THR_W'(thr);

  assign prod_s = $signed({1'b0, mul_prod[SW-1:0]});
  assign lhs    = mul_prod << LHS_SHIFT;

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        case (sub_q)
          SUB_AA: begin
            mul_a = TW'(ma);
            mul_b = BW'(ma);
          end
          SUB_BB: begin
            mul_a = TW'(mb);
            mul_b = BW'(mb);
          end
          default: begin
            mul_a = TW'(ma);
            mul_b = BW'(mb);
          end
        endcase
      end
      ST_CM2: begin
        mul_a = TW'(cm);
        mul_b = BW'(cm);
      end
      ST_T1: begin
        mul_a = TW'(s1_q);
        mul_b = BW'(mul_prod[CM2_W-1:0]);
      end
      ST_T2: begin
        mul_a = mul_prod[TW-1:0];
        mul_b = BW'(s2_q);
      end
      ST_DOT: begin
        mul_a = TW'(dmag);
        mul_b = BW'(dmag);
      end
      default: ;
    endcase
  end

  pcsd_mul #(
    .AW (TW),
    .BW (BW),
    .PW (PW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign out_free = !out_valid_q || m_ready_i;
  assign base_spd = job_ctl_i.mid_ov ? mid_spd : def_speed_i;

  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    k_d       = k_q;
    sub_d     = sub_q;
    slow_d    = slow_q;
    s1_d      = s1_q;
    s2_d      = s2_q;
    dot_d     = dot_q;
    rhs_d     = rhs_q;
    mul_start = 1'b0;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    nx_slow   = 1'b0;
    nx_ov     = 1'b0;
    nx_spd    = '0;
    nx_last   = 1'b0;

    unique case (state_q) inside
      ST_IDLE: begin
        if (q_valid_i) begin
          if (job_ctl_i.test) begin
            state_d = ST_SQ;
            iss_d   = 1'b1;
            k_d     = K_X;
            sub_d   = SUB_AA;
            s1_d    = '0;
            s2_d    = '0;
            dot_d   = '0;
          end else begin
            slow_d  = 1'b0;
            state_d = job_ctl_i.emit_mid ? ST_MID : ST_LAST;
          end
        end
      end
      ST_SQ: begin
        if (iss_q) begin
          mul_start = 1'b1;
          iss_d     = 1'b0;
        end else if (mul_done) begin
          case (sub_q)
            SUB_AA: s1_d = s1_q + mul_prod[SW-1:0];
            SUB_BB: s2_d = s2_q + mul_prod[SW-1:0];
            default: dot_d = (da[DW-1] ^ db[DW-1]) ? dot_q - prod_s : dot_q + prod_s;
          endcase
          if (sub_q == SUB_AB) begin
            sub_d = SUB_AA;
            if (k_q == K_Z) begin
              state_d = ST_CHK;
            end else begin
              k_d   = k_q + 2'd1;
              iss_d = 1'b1;
            end
          end else begin
            sub_d = sub_q + 2'd1;
            iss_d = 1'b1;
          end
        end
      end
      ST_CHK: begin
        // a zero-length neighbor vector skips the test
        if ((s1_q == '0) || (s2_q == '0)) begin
          slow_d  = 1'b0;
          state_d = ST_MID;
        end else begin
          state_d = ST_CM2;
          iss_d   = 1'b1;
        end
      end
      ST_CM2, ST_T1, ST_T2, ST_DOT: begin
        if (iss_q) begin
          mul_start = 1'b1;
          iss_d     = 1'b0;
        end else if (mul_done) begin
          iss_d = 1'b1;
          case (state_q)
            ST_CM2: state_d = ST_T1;
            ST_T1:  state_d = ST_T2;
            ST_T2: begin
              rhs_d   = mul_prod;
              state_d = ST_DOT;
            end
            default: begin
              // dot^2 << 28 against s1*s2*c^2, sign cases first
              if (thr[THR_W-1]) begin
                slow_d = !dneg || (lhs < rhs_q);
              end else begin
                slow_d = !dneg && (dmag != '0) && (lhs > rhs_q);
              end
              iss_d   = 1'b0;
              state_d = ST_MID;
            end
          endcase
        end
      end
      ST_MID: begin
        if (out_free) begin
          out_load = 1'b1;
          nx_slow  = slow_q;
          nx_ov    = slow_q | job_ctl_i.mid_ov;
          nx_spd   = slow_q ? (base_spd >> 1) : mid_spd;
          nx_last  = 1'b0;
          if (job_ctl_i.emit_last) begin
            state_d = ST_LAST;
          end else begin
            q_pop_o = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_LAST: begin
        if (out_free) begin
          out_load = 1'b1;
          nx_slow  = 1'b0;
          nx_ov    = job_ctl_i.last_ov;
          nx_spd   = last_spd;
          nx_last  = 1'b1;
          q_pop_o  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= 1'b0;
      k_q         <= K_X;
      sub_q       <= SUB_AA;
      slow_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      k_q         <= k_d;
      sub_q       <= sub_d;
      slow_q      <= slow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    dot_q <= dot_d;
    rhs_q <= rhs_d;
    if (out_load) begin
      out_slow_q <= nx_slow;
      out_ov_q   <= nx_ov;
      out_spd_q  <= nx_spd;
      out_last_q <= nx_last;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign slowed_o   = out_slow_q;
  assign override_o = out_ov_q;
  assign speed_o    = out_spd_q;
  assign last_o     = out_last_q;

endmodule

[sv/path_corner_slowdown_detector.sv]
// ----------------------------------------------------------------------------
// path_corner_slowdown_detector
// Marks interior corner points of mark segments for a halved speed.
// ----------------------------------------------------------------------------
// Points stream in on s_axis, one per item, tlast on the last point of a
// segment. A point's result leaves on m_axis when the next point of its
// segment arrives; a segment's last point also yields its own result, so
// one input item gives zero, one or two results. The front end takes a
// point into a two-entry job queue; the back end then works on one job at
// a time. An untested point goes from idle straight to its output states.
// A tested corner runs 9 short products and, unless a neighbor vector has
// zero length, c^2, s1*c^2, *s2 and dot^2 (13 in all) through a single
// multiplier that consumes one 16-bit digit per cycle and stops early once
// the remaining digits of its second operand are zero. A held-off output
// stalls the back end, and s_axis_tready drops once the queue is full.
// Write configuration only while no point is in flight; cfg_ready_o is
// always high.
// ----------------------------------------------------------------------------
module path_corner_slowdown_detector import pcsd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 20,
  parameter int unsigned SPEED_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: x_pos, y_pos, z_pos, speed_in, zero pad
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [((3*COORD_WIDTH+SPEED_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser: is_mark, has_override
  input  logic [1:0]            s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: speed_out, zero pad
  output logic [((SPEED_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // tuser: slowed, override_out
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [SPEED_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned C      = COORD_WIDTH;
  localparam int unsigned OUT_TW = ((SPEED_WIDTH + 7) / 8) * 8;
  localparam int unsigned JW     = JOB_CTL_W + 9 * C + 2 * SPEED_WIDTH;

  logic [THR_W-1:0]       cos_thr_q;
  logic [SPEED_WIDTH-1:0] def_speed_q;

  logic                   push, q_ready, q_valid, q_pop;
  pcsd_job_ctl_t          in_ctl, out_ctl;
  logic [9*C-1:0]         in_pts;
  logic [2*SPEED_WIDTH-1:0] in_spd;
  logic [JW-1:0]          q_din, q_dout;
  logic [SPEED_WIDTH-1:0] speed_out;
  logic                   slowed, ov_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_thr_q   <= '0;
      def_speed_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_COS_THR:   cos_thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_DEF_SPEED: def_speed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcsd_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .x_pos_i        ($signed(s_axis_tdata[0 +: C])),
    .y_pos_i        ($signed(s_axis_tdata[C +: C])),
    .z_pos_i        ($signed(s_axis_tdata[2*C +: C])),
    .is_mark_i      (s_axis_tuser[0]),
    .seg_end_i      (s_axis_tlast),
    .has_override_i (s_axis_tuser[1]),
    .speed_in_i     (s_axis_tdata[3*C +: SPEED_WIDTH]),
    .push_o         (push),
    .q_ready_i      (q_ready),
    .job_ctl_o      (in_ctl),
    .job_pts_o      (in_pts),
    .job_spd_o      (in_spd)
  );

  assign q_din = {in_ctl, in_pts, in_spd};

  pcsd_queue #(
    .W (JW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (q_din),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .dout_o  (q_dout)
  );

  assign out_ctl = pcsd_job_ctl_t'(q_dout[JW-1 -: JOB_CTL_W]);

  pcsd_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .job_ctl_i   (out_ctl),
    .job_pts_i   (q_dout[2*SPEED_WIDTH +: 9*C]),
    .job_spd_i   (q_dout[0 +: 2*SPEED_WIDTH]),
    .cos_thr_i   (cos_thr_q),
    .def_speed_i (def_speed_q),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .slowed_o    (slowed),
    .override_o  (ov_out),
    .speed_o     (speed_out),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TW'(speed_out);
  assign m_axis_tuser = {ov_out, slowed};

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the path corner slowdown detector.
// A directed list of path points (field extremes, straight runs, reversals,
// zero-length neighbors, short and non-mark segments) is followed by random
// segments that walk through space with straight, reversing and turning
// steps. Each accepted point runs through a local model of the corner test
// and the speed halving, and every result leaving the block is checked
// against the oldest predicted result. Both stream sides idle at random,
// and once the output is held off long enough for the block to stall.
// ----------------------------------------------------------------------------
module tb_top import pcsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_W = 20;
  localparam int unsigned SPEED_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SPEED_W-1:0] speed_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   mark;
    logic   last;
    logic   ov;
    speed_t spd;
  } path_point_t;

  typedef struct packed {
    logic   slowed;
    logic   ov;
    speed_t speed;
    logic   last;
  } point_result_t;

  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] addr;
    speed_t               data;
    path_point_t          pt;
    logic                 typed;
    point_result_t        want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [95:0]           s_axis_tdata;   // x_pos, y_pos, z_pos, speed_in, pad
  logic [1:0]            s_axis_tuser;   // is_mark, has_override
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;   // speed_out
  logic [1:0]            m_axis_tuser;   // slowed, override_out
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [SPEED_W-1:0]    cfg_data_i;

  path_corner_slowdown_detector #(
    .COORD_WIDTH (COORD_W),
    .SPEED_WIDTH (SPEED_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // model state
  logic signed [THR_W-1:0] cos_thr;
  speed_t                  def_speed;
  coord_t                  older_pt [3];
  coord_t                  middle_pt [3];
  speed_t                  middle_spd;
  logic                    middle_ov;
  int unsigned             pts_in_seg;
  logic                    mark_seg;

  point_result_t slowdown_q [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          rx_hold_req;
  int unsigned points_sent;
  int unsigned results_checked;
  int unsigned slowed_seen;
  int unsigned cfg_writes;
  int unsigned mismatches;

  longint walk [3];
  longint walk_step [3];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d points sent, %0d results pending", points_sent, slowdown_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // exact integer form of dot/(|d1||d2|) > thr/16384
  function automatic bit corner_slows(coord_t p0 [3], coord_t p1 [3], coord_t p2 [3],
                                      logic signed [THR_W-1:0] thr);
    longint a, b, dot, c;
    longint unsigned s1, s2, mag, cm2;
    logic [127:0] lhs, rhs;
    s1  = 0;
    s2  = 0;
    dot = 0;
    for (int k = 0; k < 3; k++) begin
      a   = longint'(p1[k]) - longint'(p0[k]);
      b   = longint'(p2[k]) - longint'(p1[k]);
      s1  += a * a;
      s2  += b * b;
      dot += a * b;
    end
    if (s1 == 0 || s2 == 0) return 1'b0;
    mag = (dot < 0) ? -dot : dot;
    c   = thr;
    cm2 = (c < 0) ? (-c) * (-c) : c * c;
    lhs = {64'd0, mag} * {64'd0, mag};
    lhs = lhs << 28;
    rhs = {64'd0, s1} * {64'd0, s2} * {64'd0, cm2};
    if (c >= 0) return (dot > 0) && (lhs > rhs);
    return (dot >= 0) || (lhs < rhs);
  endfunction

  // advance the path state by one point and queue the results it releases
  task automatic follow_path_point(path_point_t p);
    coord_t        pt [3];
    point_result_t r;
    logic          mov;
    speed_t        mspd;
    pt[0] = p.x;
    pt[1] = p.y;
    pt[2] = p.z;
    if (pts_in_seg == 0) begin
      mark_seg = p.mark;
    end else begin
      r.slowed = 1'b0;
      mov      = middle_ov;
      mspd     = middle_spd;
      if (pts_in_seg >= 2 && mark_seg && corner_slows(older_pt, middle_pt, pt, cos_thr)) begin
        r.slowed = 1'b1;
        mspd     = (mov ? mspd : def_speed) >> 1;
        mov      = 1'b1;
      end
      r.ov    = mov;
      r.speed = mov ? mspd : '0;
      r.last  = 1'b0;
      slowdown_q = {slowdown_q, r};
    end
    older_pt   = middle_pt;
    middle_pt  = pt;
    middle_spd = p.ov ? p.spd : '0;
    middle_ov  = p.ov;
    if (p.last) begin
      r.slowed = 1'b0;
      r.ov     = p.ov;
      r.speed  = p.ov ? p.spd : '0;
      r.last   = 1'b1;
      slowdown_q = {slowdown_q, r};
      pts_in_seg = 0;
    end else if (pts_in_seg < 2) begin
      pts_in_seg++;
    end
  endtask

  task automatic send_point(path_point_t p, logic typed, point_result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, p.spd, p.z, p.y, p.x};
    s_axis_tuser  <= {p.ov, p.mark};
    s_axis_tlast  <= p.last;
    do @(posedge clk_i); while (!s_axis_tready);
    follow_path_point(p);
    if (typed) slowdown_q[$] = want;
    points_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, speed_t data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (addr == CFG_COS_THR) cos_thr = data[THR_W-1:0];
    else def_speed = data;
    cfg_writes++;
  endtask

  // stop offering, drain, then cover a trailing job that yields no result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (slowdown_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic dir_row_t pt_row(int x, int y, int z, bit mark, bit last, bit ov,
                                      speed_t spd);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.addr   = CFG_COS_THR;
    r.data   = '0;
    r.pt     = '{x: coord_t'(x), y: coord_t'(y), z: coord_t'(z), mark: mark, last: last,
                 ov: ov, spd: spd};
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] addr, speed_t data);
    dir_row_t r;
    r        = pt_row(0, 0, 0, 0, 0, 0, '0);
    r.is_cfg = 1'b1;
    r.addr   = addr;
    r.data   = data;
    return r;
  endfunction

  function automatic dir_row_t with_want(dir_row_t r, bit slowed, bit ov, speed_t spd,
                                         bit last);
    r.typed = 1'b1;
    r.want  = '{slowed: slowed, ov: ov, speed: spd, last: last};
    return r;
  endfunction

  function automatic speed_t pick_speed();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return speed_t'(1);
    return speed_t'($urandom);
  endfunction

  // next point of a random walk: straight, reversing, turning or jumping
  task automatic next_walk_point(bit mark, bit last, output path_point_t p);
    int unsigned sel;
    coord_t      c [3];
    sel = $urandom_range(99);
    for (int k = 0; k < 3; k++) begin
      if (sel < 35) walk_step[k] = longint'($urandom_range(8000)) - 4000;
      else if (sel < 55) walk_step[k] = walk_step[k];
      else if (sel < 65) walk_step[k] = -walk_step[k];
      else if (sel < 72) walk_step[k] = 0;
      else if (sel >= 80) walk_step[k] += longint'($urandom_range(100)) - 50;
      if (sel >= 72 && sel < 80) begin
        case ($urandom_range(3))
          0:       c[k] = {1'b1, {(COORD_W-1){1'b0}}};
          1:       c[k] = {1'b0, {(COORD_W-1){1'b1}}};
          default: c[k] = coord_t'($urandom);
        endcase
      end else begin
        c[k] = coord_t'(walk[k] + walk_step[k]);
      end
      walk[k] = c[k];
    end
    p = '{x: c[0], y: c[1], z: c[2], mark: mark, last: last,
          ov: ($urandom_range(99) < 40), spd: pick_speed()};
  endtask

  task automatic send_segment(int unsigned len, bit mark);
    path_point_t p;
    for (int unsigned i = 0; i < len; i++) begin
      // later points carry a random is_mark, which must be ignored
      next_walk_point((i == 0) ? mark : 1'($urandom_range(1)), i == len - 1, p);
      send_point(p, 1'b0, '0);
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    point_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{slowed: m_axis_tuser[0], ov: m_axis_tuser[1], speed: m_axis_tdata,
              last: m_axis_tlast};
      if (slowdown_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result slowed=%0b ov=%0b speed=%h last=%0b",
                   $realtime, got.slowed, got.ov, got.speed, got.last);
      end else begin
        want = slowdown_q.pop_front();
        results_checked++;
        if (want.slowed) slowed_seen++;
        if (got.slowed !== want.slowed || got.ov !== want.ov ||
            got.speed !== want.speed || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp slowed=%0b ov=%0b speed=%h last=%0b, got %0b %0b %h %0b",
                     $realtime, want.slowed, want.ov, want.speed, want.last,
                     got.slowed, got.ov, got.speed, got.last);
        end
      end
    end
  end

  initial begin
    dir_row_t    rows [$];
    logic signed [THR_W-1:0] thr;
    speed_t      spd;
    int unsigned sent;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= CFG_COS_THR;
    cfg_data_i    <= '0;
    rx_hold_req     = 1'b0;
    tx_idle_pct     = 7;
    rx_idle_pct     = 65;
    points_sent     = 0;
    results_checked = 0;
    slowed_seen     = 0;
    cfg_writes      = 0;
    mismatches      = 0;
    cos_thr         = '0;
    def_speed       = '0;
    middle_spd      = '0;
    middle_ov       = 1'b0;
    pts_in_seg      = 0;
    mark_seg        = 1'b0;
    for (int k = 0; k < 3; k++) begin
      older_pt[k]  = '0;
      middle_pt[k] = '0;
      walk[k]      = 0;
      walk_step[k] = 100;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset settings first
    rows = {rows, with_want(pt_row(0, 0, 0, 1, 1, 0, '1), 0, 0, '0, 1)};
    rows = {rows, with_want(pt_row(-524288, 524287, 0, 0, 1, 1, '1), 0, 1, '1, 1)};
    rows = {rows, pt_row(0, 0, 0, 1, 0, 0, '0)};
    rows = {rows, pt_row(1000, 0, 0, 0, 0, 0, '0)};
    rows = {rows, with_want(pt_row(2000, 0, 0, 0, 1, 0, '0), 0, 0, '0, 1)};
    // cos exactly at threshold: straight run must not slow
    rows = {rows, cfg_row(CFG_COS_THR, speed_t'(16384))};
    rows = {rows, cfg_row(CFG_DEF_SPEED, '1)};
    rows = {rows, pt_row(0, 0, 0, 1, 0, 0, '0)};
    rows = {rows, pt_row(7, 0, 0, 1, 0, 1, 32'h8000_0001)};
    rows = {rows, with_want(pt_row(14, 0, 0, 1, 1, 0, '0), 0, 0, '0, 1)};
    // full reversals between coordinate extremes
    rows = {rows, cfg_row(CFG_COS_THR, speed_t'(16'(-16384)))};
    rows = {rows, pt_row(-524288, -524288, -524288, 1, 0, 0, '0)};
    rows = {rows, pt_row(524287, 524287, 524287, 0, 0, 0, '0)};
    rows = {rows, pt_row(-524288, -524288, -524288, 0, 0, 1, 32'h8000_0001)};
    rows = {rows, pt_row(524287, 524287, 524287, 0, 1, 0, '0)};
    // zero-length neighbor, then threshold below -1
    rows = {rows, cfg_row(CFG_COS_THR, speed_t'(16'h8000))};
    rows = {rows, pt_row(5, 5, 5, 1, 0, 0, '0)};
    rows = {rows, pt_row(5, 5, 5, 1, 0, 1, 32'h10)};
    rows = {rows, pt_row(9, -9, 9, 1, 0, 0, '0)};
    rows = {rows, pt_row(1, 2, 3, 1, 1, 1, 32'h0001_0000)};
    // threshold above 1; non-mark, gentle corner and two-point segments
    rows = {rows, cfg_row(CFG_COS_THR, speed_t'(16'h7fff))};
    rows = {rows, pt_row(0, 0, 0, 0, 0, 0, '0)};
    rows = {rows, pt_row(1, 0, 0, 1, 0, 0, '0)};
    rows = {rows, pt_row(2, 0, 0, 1, 1, 0, '0)};
    rows = {rows, pt_row(0, 0, 0, 1, 0, 1, 32'h1234_5678)};
    rows = {rows, pt_row(100, 0, 0, 1, 0, 0, '0)};
    rows = {rows, pt_row(200, 1, 0, 1, 1, 0, '0)};
    rows = {rows, pt_row(3, 3, 3, 1, 0, 0, '0)};
    rows = {rows, with_want(pt_row(4, 4, 4, 1, 1, 1, '0), 0, 1, '0, 1)};

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_reg(rows[i].addr, rows[i].data);
      end else begin
        send_point(rows[i].pt, rows[i].typed, rows[i].want);
      end
    end

    // random part: six settings, three idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      tx_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 65 : 0;
      rx_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 7 : 0;
      case (ph)
        0:       thr = THR_W'(int'($urandom_range(32768)) - 16384);
        1:       thr = THR_W'($urandom_range(16384, 8000));
        2:       thr = THR_W'(-16384);
        3:       thr = THR_W'(16384);
        4:       thr = THR_W'($urandom_range(65535));
        default: thr = THR_W'(int'($urandom_range(32768)) - 16384);
      endcase
      spd = (ph == 2) ? '1 : (ph == 3) ? '0 : speed_t'($urandom);
      write_reg(CFG_COS_THR, speed_t'(thr));
      write_reg(CFG_DEF_SPEED, spd);
      if (ph == 2) rx_hold_req = 1'b1;
      sent = 0;
      while (sent < 290) begin
        int unsigned len;
        bit          mark;
        if ($urandom_range(99) < 85) begin
          len  = ($urandom_range(99) < 5) ? $urandom_range(20, 12) : $urandom_range(8, 3);
          mark = 1'b1;
        end else if ($urandom_range(1)) begin
          len  = $urandom_range(2, 1);
          mark = 1'($urandom_range(1));
        end else begin
          len  = $urandom_range(6, 1);
          mark = 1'b0;
        end
        send_segment(len, mark);
        sent += len;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (slowdown_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d path points and %0d results, %0d of them slowed corners,",
             points_sent, results_checked, slowed_seen);
    $display("over %0d register writes, idle/stall mixes and one long output hold-off.",
             cfg_writes);
    if (mismatches == 0 && slowdown_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, slowdown_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
